@@ hw/rtl/dhfk_pkg.sv @@
// dhfk_pkg: widths, fixed-point constants, arctangent table and pipeline types
// for the six-joint forward kinematics pipeline. No dependencies.
`default_nettype none

package dhfk_pkg;

    localparam int FRAC_BITS       = 16;
    localparam int CF              = 30;
    localparam int SH              = CF - FRAC_BITS;
    localparam int TRIG_STAGES_DEF = 16;
    localparam int ATAN_COUNT      = 24;

    localparam int ANG_W  = 20;
    localparam int CFG_W  = 17;
    localparam int NUM_CFG = 5;
    localparam int POS_W  = 21;
    localparam int ROT_W  = 18;
    localparam int TW     = FRAC_BITS + 2;
    localparam int RW     = FRAC_BITS + 4;
    localparam int PSW    = POS_W + 3;
    localparam int ZW     = ANG_W + SH + 2;
    localparam int XW     = CF + 4;
    localparam int APB_DW = 32;
    localparam int APB_AW = $clog2(NUM_CFG * 4);

    localparam logic signed [ZW-1:0] PI_Q      = ZW'(64'sd3373259426);
    localparam logic signed [ZW-1:0] HALF_PI_Q = ZW'(64'sd1686629713);
    localparam logic signed [ZW-1:0] TWO_PI_Q  = ZW'(64'sd6746518852);
    localparam logic signed [XW-1:0] GAIN_Q    = XW'(64'sd652032874);

    typedef enum logic [APB_AW-3:0] {
        REG_BASE_OFFSET      = 'd0,
        REG_UPPER_ARM_OFFSET = 'd1,
        REG_FOREARM_OFFSET   = 'd2,
        REG_TOOL_OFFSET      = 'd3,
        REG_TOOL_LENGTH      = 'd4
    } cfg_idx_t;

    localparam logic [CFG_W-1:0] RST_BASE_OFFSET      = CFG_W'(29164);
    localparam logic [CFG_W-1:0] RST_UPPER_ARM_OFFSET = CFG_W'(17695);
    localparam logic [CFG_W-1:0] RST_FOREARM_OFFSET   = CFG_W'(15729);
    localparam logic [CFG_W-1:0] RST_TOOL_OFFSET      = CFG_W'(3277);
    localparam logic [CFG_W-1:0] RST_TOOL_LENGTH      = CFG_W'(9175);

    typedef struct packed {
        logic signed [TW-1:0] c;
        logic signed [TW-1:0] s;
    } cs_t;

    typedef logic signed [RW-1:0]  rot_t;
    typedef logic signed [PSW-1:0] pos_t;

    typedef struct packed {
        rot_t [2:0][2:0] r;
        pos_t [2:0]      p;
        cs_t  [5:0]      cs;
    } kin_t;

    function automatic logic [30:0] atan_q(input int i);
        logic [30:0] v;
        case (i)
            0:       v = 31'd843314857;
            1:       v = 31'd497837829;
            2:       v = 31'd263043837;
            3:       v = 31'd133525159;
            4:       v = 31'd67021687;
            5:       v = 31'd33543516;
            6:       v = 31'd16775851;
            7:       v = 31'd8388437;
            8:       v = 31'd4194283;
            9:       v = 31'd2097149;
            10:      v = 31'd1048576;
            11:      v = 31'd524288;
            12:      v = 31'd262144;
            13:      v = 31'd131072;
            14:      v = 31'd65536;
            15:      v = 31'd32768;
            16:      v = 31'd16384;
            17:      v = 31'd8192;
            18:      v = 31'd4096;
            19:      v = 31'd2048;
            20:      v = 31'd1024;
            21:      v = 31'd512;
            22:      v = 31'd256;
            23:      v = 31'd128;
            default: v = 31'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/dhfk_if.sv @@
// dhfk_joint_if and dhfk_pose_if: valid/ready channels for joint vectors and poses.
// Depends on dhfk_pkg for field widths.
`default_nettype none

interface dhfk_joint_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [dhfk_pkg::ANG_W-1:0]    joint_angle_0;
    logic signed [dhfk_pkg::ANG_W-1:0]    joint_angle_1;
    logic signed [dhfk_pkg::ANG_W-1:0]    joint_angle_2;
    logic signed [dhfk_pkg::ANG_W-1:0]    joint_angle_3;
    logic signed [dhfk_pkg::ANG_W-1:0]    joint_angle_4;
    logic signed [dhfk_pkg::ANG_W-1:0]    joint_angle_5;

    modport source (
        output valid, joint_angle_0, joint_angle_1, joint_angle_2,
               joint_angle_3, joint_angle_4, joint_angle_5,
        input  ready
    );
    modport sink (
        input  valid, joint_angle_0, joint_angle_1, joint_angle_2,
               joint_angle_3, joint_angle_4, joint_angle_5,
        output ready
    );
endinterface

interface dhfk_pose_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [dhfk_pkg::POS_W-1:0]    pos_x;
    logic signed [dhfk_pkg::POS_W-1:0]    pos_y;
    logic signed [dhfk_pkg::POS_W-1:0]    pos_z;
    logic signed [dhfk_pkg::ROT_W-1:0]    rot_00;
    logic signed [dhfk_pkg::ROT_W-1:0]    rot_01;
    logic signed [dhfk_pkg::ROT_W-1:0]    rot_02;
    logic signed [dhfk_pkg::ROT_W-1:0]    rot_10;
    logic signed [dhfk_pkg::ROT_W-1:0]    rot_11;
    logic signed [dhfk_pkg::ROT_W-1:0]    rot_12;
    logic signed [dhfk_pkg::ROT_W-1:0]    rot_20;
    logic signed [dhfk_pkg::ROT_W-1:0]    rot_21;
    logic signed [dhfk_pkg::ROT_W-1:0]    rot_22;

    modport source (
        output valid, pos_x, pos_y, pos_z, rot_00, rot_01, rot_02,
               rot_10, rot_11, rot_12, rot_20, rot_21, rot_22,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, pos_z, rot_00, rot_01, rot_02,
               rot_10, rot_11, rot_12, rot_20, rot_21, rot_22,
        output ready
    );
endinterface

`default_nettype wire

@@ hw/rtl/dhfk_trig.sv @@
// dhfk_trig: pipelined sine/cosine of one joint angle, range reduction then CORDIC.
// Depends on dhfk_pkg. All registers advance only while en is high.
`default_nettype none

module dhfk_trig #(
    parameter int STAGES = dhfk_pkg::TRIG_STAGES_DEF
) (
    input  wire                               clk,
    input  wire                               en,
    input  wire signed [dhfk_pkg::ANG_W-1:0]  angle,
    output dhfk_pkg::cs_t                     cs
);
    import dhfk_pkg::*;

    localparam logic signed [XW-1:0] RND_T = XW'(1) <<< (SH - 1);
    localparam logic signed [XW-1:0] ONE_X = XW'(1) <<< FRAC_BITS;

    logic signed [ZW-1:0] ang;
    logic signed [ZW-1:0] zm_next, zm_reg;
    logic signed [XW-1:0] zf_next, zf_reg;
    logic                 ff_next, ff_reg;
    logic signed [XW-1:0] cx_reg [STAGES];
    logic signed [XW-1:0] cy_reg [STAGES];
    logic signed [XW-1:0] cz_reg [STAGES];
    logic                 cf_reg [STAGES];
    cs_t                  cs_next, cs_reg;

    assign ang = {{2{angle[ANG_W-1]}}, angle, {SH{1'b0}}};

    always_comb
    begin
        if (ang >= TWO_PI_Q)
            zm_next = ang - TWO_PI_Q;
        else if (ang <= -TWO_PI_Q)
            zm_next = ang + TWO_PI_Q;
        else
            zm_next = ang;
    end

    always_comb
    begin
        logic signed [ZW-1:0] z2;
        logic signed [ZW-1:0] z3;
        if (zm_reg > PI_Q)
            z2 = zm_reg - TWO_PI_Q;
        else if (zm_reg < -PI_Q)
            z2 = zm_reg + TWO_PI_Q;
        else
            z2 = zm_reg;
        ff_next = 1'b0;
        z3 = z2;
        if (z2 > HALF_PI_Q)
        begin
            z3 = z2 - PI_Q;
            ff_next = 1'b1;
        end
        else if (z2 < -HALF_PI_Q)
        begin
            z3 = z2 + PI_Q;
            ff_next = 1'b1;
        end
        zf_next = z3[XW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zm_reg <= zm_next;
            zf_reg <= zf_next;
            ff_reg <= ff_next;
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        logic signed [XW-1:0] xi, yi, zi;
        logic                 fi;
        logic signed [XW-1:0] at;

        if (i == 0)
        begin : g_first
            assign xi = GAIN_Q;
            assign yi = '0;
            assign zi = zf_reg;
            assign fi = ff_reg;
        end
        else
        begin : g_rest
            assign xi = cx_reg[i-1];
            assign yi = cy_reg[i-1];
            assign zi = cz_reg[i-1];
            assign fi = cf_reg[i-1];
        end

        assign at = $signed({{(XW-31){1'b0}}, atan_q(i)});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!zi[XW-1])
                begin
                    cx_reg[i] <= xi - (yi >>> i);
                    cy_reg[i] <= yi + (xi >>> i);
                    cz_reg[i] <= zi - at;
                end
                else
                begin
                    cx_reg[i] <= xi + (yi >>> i);
                    cy_reg[i] <= yi - (xi >>> i);
                    cz_reg[i] <= zi + at;
                end
                cf_reg[i] <= fi;
            end
        end
    end

    always_comb
    begin
        logic signed [XW-1:0] xo, yo, rc, rs;
        xo = cf_reg[STAGES-1] ? -cx_reg[STAGES-1] : cx_reg[STAGES-1];
        yo = cf_reg[STAGES-1] ? -cy_reg[STAGES-1] : cy_reg[STAGES-1];
        rc = (xo + RND_T) >>> SH;
        rs = (yo + RND_T) >>> SH;
        if (rc > ONE_X)
            rc = ONE_X;
        else if (rc < -ONE_X)
            rc = -ONE_X;
        if (rs > ONE_X)
            rs = ONE_X;
        else if (rs < -ONE_X)
            rs = -ONE_X;
        cs_next.c = rc[TW-1:0];
        cs_next.s = rs[TW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            cs_reg <= cs_next;
    end

    assign cs = cs_reg;

endmodule

`default_nettype wire

@@ hw/rtl/dhfk_link.sv @@
// dhfk_link: one twisted link transform applied to the running pose,
// products in the first stage, sums and rounding in the second. Depends on dhfk_pkg.
`default_nettype none

module dhfk_link #(
    parameter bit TWIST_NEG = 1'b0
) (
    input  wire                                clk,
    input  wire                                en,
    input  wire dhfk_pkg::kin_t                kin_in,
    input  wire signed [dhfk_pkg::TW-1:0]      c,
    input  wire signed [dhfk_pkg::TW-1:0]      s,
    input  wire [dhfk_pkg::CFG_W-1:0]          d,
    input  wire [dhfk_pkg::CFG_W-1:0]          a,
    output dhfk_pkg::kin_t                     kin_out
);
    import dhfk_pkg::*;

    localparam int PW = RW + CFG_W + 1;
    localparam int SW = PW + 1;
    localparam logic signed [SW-1:0] RND_F = SW'(1) <<< (FRAC_BITS - 1);

    logic signed [CFG_W:0] a_s, d_s;
    logic signed [PW-1:0]  m0c_reg [3];
    logic signed [PW-1:0]  m2s_reg [3];
    logic signed [PW-1:0]  m0s_reg [3];
    logic signed [PW-1:0]  m2c_reg [3];
    logic signed [PW-1:0]  m0a_reg [3];
    logic signed [PW-1:0]  m1d_reg [3];
    kin_t                  hold_reg;
    kin_t                  kin_next, kin_reg;

    assign a_s = $signed({1'b0, a});
    assign d_s = $signed({1'b0, d});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hold_reg <= kin_in;
            for (int j = 0; j < 3; j++)
            begin
                m0c_reg[j] <= $signed(kin_in.r[j][0]) * c;
                m2s_reg[j] <= $signed(kin_in.r[j][2]) * s;
                m0s_reg[j] <= $signed(kin_in.r[j][0]) * s;
                m2c_reg[j] <= $signed(kin_in.r[j][2]) * c;
                m0a_reg[j] <= $signed(kin_in.r[j][0]) * a_s;
                m1d_reg[j] <= $signed(kin_in.r[j][1]) * d_s;
            end
        end
    end

    always_comb
    begin
        logic signed [SW-1:0] sum0, sum1, sump;
        logic signed [SW-1:0] r0, r1, rp;
        kin_next = hold_reg;
        for (int j = 0; j < 3; j++)
        begin
            if (TWIST_NEG)
            begin
                sum0 = m0c_reg[j] - m2s_reg[j];
                sum1 = -m0s_reg[j] - m2c_reg[j];
                sump = m0a_reg[j] + m1d_reg[j];
                kin_next.r[j][2] = hold_reg.r[j][1];
            end
            else
            begin
                sum0 = m0c_reg[j] + m2s_reg[j];
                sum1 = m2c_reg[j] - m0s_reg[j];
                sump = m0a_reg[j] - m1d_reg[j];
                kin_next.r[j][2] = -hold_reg.r[j][1];
            end
            r0 = (sum0 + RND_F) >>> FRAC_BITS;
            r1 = (sum1 + RND_F) >>> FRAC_BITS;
            rp = (sump + RND_F) >>> FRAC_BITS;
            kin_next.r[j][0] = r0[RW-1:0];
            kin_next.r[j][1] = r1[RW-1:0];
            kin_next.p[j]    = rp[PSW-1:0] + hold_reg.p[j];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            kin_reg <= kin_next;
    end

    assign kin_out = kin_reg;

endmodule

`default_nettype wire

@@ hw/rtl/dh_forward_kinematics.sv @@
// dh_forward_kinematics: top level of the six-joint forward kinematics pipeline.
// Depends on dhfk_pkg, dhfk_if, dhfk_trig and dhfk_link.
//
// Takes one joint vector per clock while joint_in.ready is high and returns the
// tool position and rotation matrix through registered angle reduction, the
// CORDIC stages, rounding, the product and sum stages of each of the six links
// and output saturation. The whole pipeline holds while a finished pose waits on
// pose_out, so joint_in.ready is low only then. Link offsets and tool length
// sit in five APB registers and are read by the pipeline directly.
`default_nettype none

module dh_forward_kinematics #(
    parameter int TRIG_STAGES = dhfk_pkg::TRIG_STAGES_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    dhfk_joint_if.sink                       joint_in,
    dhfk_pose_if.source                      pose_out,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire [dhfk_pkg::APB_AW-1:0]       paddr,
    input  wire [dhfk_pkg::APB_DW-1:0]       pwdata,
    output logic [dhfk_pkg::APB_DW-1:0]      prdata,
    output logic                             pready
);
    import dhfk_pkg::*;

    localparam int LAT = TRIG_STAGES + 16;

    localparam logic signed [PSW-1:0] POS_MAX = PSW'((64'sd1 <<< (POS_W - 1)) - 1);
    localparam logic signed [PSW-1:0] POS_MIN = -PSW'(64'sd1 <<< (POS_W - 1));
    localparam logic signed [RW-1:0]  ONE_R   = RW'(1) <<< FRAC_BITS;

    logic [CFG_W-1:0]       cfg_reg [NUM_CFG];
    cfg_idx_t               cfg_idx;
    logic                   advance;
    logic [LAT-1:0]         vld_next, vld_reg;
    logic signed [ANG_W-1:0] ang_w [6];
    cs_t                    cs_w [6];
    kin_t                   kin_base;
    kin_t                   kin_w [7];
    logic signed [POS_W-1:0] pos_next [3];
    logic signed [POS_W-1:0] pos_reg  [3];
    logic signed [ROT_W-1:0] rot_next [3][3];
    logic signed [ROT_W-1:0] rot_reg  [3][3];

    // configuration port
    assign pready  = 1'b1;
    assign cfg_idx = cfg_idx_t'(paddr[APB_AW-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[0] <= RST_BASE_OFFSET;
            cfg_reg[1] <= RST_UPPER_ARM_OFFSET;
            cfg_reg[2] <= RST_FOREARM_OFFSET;
            cfg_reg[3] <= RST_TOOL_OFFSET;
            cfg_reg[4] <= RST_TOOL_LENGTH;
        end
        else if (psel && penable && pwrite)
        begin
            case (cfg_idx)
                REG_BASE_OFFSET:      cfg_reg[0] <= pwdata[CFG_W-1:0];
                REG_UPPER_ARM_OFFSET: cfg_reg[1] <= pwdata[CFG_W-1:0];
                REG_FOREARM_OFFSET:   cfg_reg[2] <= pwdata[CFG_W-1:0];
                REG_TOOL_OFFSET:      cfg_reg[3] <= pwdata[CFG_W-1:0];
                REG_TOOL_LENGTH:      cfg_reg[4] <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_BASE_OFFSET:      prdata = APB_DW'(cfg_reg[0]);
            REG_UPPER_ARM_OFFSET: prdata = APB_DW'(cfg_reg[1]);
            REG_FOREARM_OFFSET:   prdata = APB_DW'(cfg_reg[2]);
            REG_TOOL_OFFSET:      prdata = APB_DW'(cfg_reg[3]);
            REG_TOOL_LENGTH:      prdata = APB_DW'(cfg_reg[4]);
            default:              prdata = '0;
        endcase
    end

    // pipeline control
    assign advance        = !vld_reg[LAT-1] || pose_out.ready;
    assign joint_in.ready = advance;
    assign vld_next       = {vld_reg[LAT-2:0], joint_in.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (advance)
            vld_reg <= vld_next;
    end

    // sine and cosine lanes
    assign ang_w[0] = joint_in.joint_angle_0;
    assign ang_w[1] = joint_in.joint_angle_1;
    assign ang_w[2] = joint_in.joint_angle_2;
    assign ang_w[3] = joint_in.joint_angle_3;
    assign ang_w[4] = joint_in.joint_angle_4;
    assign ang_w[5] = joint_in.joint_angle_5;

    for (genvar k = 0; k < 6; k++)
    begin : g_trig
        dhfk_trig #(
            .STAGES (TRIG_STAGES)
        ) u_trig (
            .clk   (clk),
            .en    (advance),
            .angle (ang_w[k]),
            .cs    (cs_w[k])
        );
    end

    // base link has no twist: its transform is the starting pose
    always_comb
    begin
        kin_base = '0;
        for (int k = 0; k < 6; k++)
            kin_base.cs[k] = cs_w[k];
        kin_base.r[0][0] = RW'(cs_w[0].c);
        kin_base.r[0][1] = -RW'(cs_w[0].s);
        kin_base.r[1][0] = RW'(cs_w[0].s);
        kin_base.r[1][1] = RW'(cs_w[0].c);
        kin_base.r[2][2] = ONE_R;
        kin_base.p[2]    = PSW'(cfg_reg[0]);
    end

    assign kin_w[0] = kin_base;

    for (genvar k = 1; k <= 6; k++)
    begin : g_link
        logic signed [TW-1:0] lc, ls;
        logic [CFG_W-1:0]     ld, la;

        if (k < 6)
        begin : g_joint
            assign lc = kin_w[k-1].cs[k].c;
            assign ls = kin_w[k-1].cs[k].s;
            assign la = '0;
        end
        else
        begin : g_tool
            assign lc = TW'(1) <<< FRAC_BITS;
            assign ls = '0;
            assign la = cfg_reg[4];
        end

        if (k == 2)
        begin : g_d_upper
            assign ld = cfg_reg[1];
        end
        else if (k == 4)
        begin : g_d_fore
            assign ld = cfg_reg[2];
        end
        else if (k == 6)
        begin : g_d_tool
            assign ld = cfg_reg[3];
        end
        else
        begin : g_d_none
            assign ld = '0;
        end

        dhfk_link #(
            .TWIST_NEG ((k % 2) == 1)
        ) u_link (
            .clk     (clk),
            .en      (advance),
            .kin_in  (kin_w[k-1]),
            .c       (lc),
            .s       (ls),
            .d       (ld),
            .a       (la),
            .kin_out (kin_w[k])
        );
    end

    // output saturation
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            if (kin_w[6].p[j] > POS_MAX)
                pos_next[j] = POS_MAX[POS_W-1:0];
            else if (kin_w[6].p[j] < POS_MIN)
                pos_next[j] = POS_MIN[POS_W-1:0];
            else
                pos_next[j] = kin_w[6].p[j][POS_W-1:0];
            for (int m = 0; m < 3; m++)
            begin
                if (kin_w[6].r[j][m] > ONE_R)
                    rot_next[j][m] = ONE_R[ROT_W-1:0];
                else if (kin_w[6].r[j][m] < -ONE_R)
                    rot_next[j][m] = ROT_W'(-ONE_R);
                else
                    rot_next[j][m] = kin_w[6].r[j][m][ROT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pos_reg <= pos_next;
            rot_reg <= rot_next;
        end
    end

    assign pose_out.valid  = vld_reg[LAT-1];
    assign pose_out.pos_x  = pos_reg[0];
    assign pose_out.pos_y  = pos_reg[1];
    assign pose_out.pos_z  = pos_reg[2];
    assign pose_out.rot_00 = rot_reg[0][0];
    assign pose_out.rot_01 = rot_reg[0][1];
    assign pose_out.rot_02 = rot_reg[0][2];
    assign pose_out.rot_10 = rot_reg[1][0];
    assign pose_out.rot_11 = rot_reg[1][1];
    assign pose_out.rot_12 = rot_reg[1][2];
    assign pose_out.rot_20 = rot_reg[2][0];
    assign pose_out.rot_21 = rot_reg[2][1];
    assign pose_out.rot_22 = rot_reg[2][2];

endmodule

`default_nettype wire

@@ hw/rtl/dhfk_checker.sv @@
// dhfk_checker: port-level assertions for dh_forward_kinematics, bound to the top.
// Depends on dhfk_pkg.
`default_nettype none

module dhfk_checker (
    input wire                                 clk,
    input wire                                 rst_n,
    input wire                                 in_ready,
    input wire                                 out_valid,
    input wire                                 out_ready,
    input wire                                 pready,
    input wire signed [dhfk_pkg::POS_W-1:0]    pos_x,
    input wire signed [dhfk_pkg::ROT_W-1:0]    rot_00
);
    import dhfk_pkg::*;

    localparam logic signed [ROT_W-1:0] ONE_O = ROT_W'(1) <<< FRAC_BITS;

    a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow output side");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(pos_x) && $stable(rot_00))
        else $error("output beat changed while stalled");

    a_rot_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (rot_00 <= ONE_O) && (rot_00 >= -ONE_O))
        else $error("rotation entry out of range");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind dh_forward_kinematics dhfk_checker u_dhfk_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (joint_in.ready),
    .out_valid (pose_out.valid),
    .out_ready (pose_out.ready),
    .pready    (pready),
    .pos_x     (pose_out.pos_x),
    .rot_00    (pose_out.rot_00)
);

`default_nettype wire
